### design/b64d_pkg.sv
`timescale 1ns / 1ps

package b64d_pkg;

    // Depth of the job queue between the character front end and the result back end.
    localparam int DEFAULT_FIFO_DEPTH = 4;

    // Width of the tdata field on the result channel: out_byte and decode_status,
    // padded to whole bytes.
    localparam int M_TDATA_W = 16;
    localparam int S_TDATA_W = 8;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_BAD_CHAR   = 2'd1,
        STATUS_BAD_LENGTH = 2'd2
    } status_t;

    // One unit of work handed from the front end to the back end: up to three
    // decoded bytes of a completed group and, at message end, a status result.
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [2:0]      byte_mask;
        logic            has_status;
        status_t         status;
    } job_t;

endpackage

### design/base64_stream_decoder.sv
`timescale 1ns / 1ps
// Path: the first result caused by a character is registered in the job queue, then in the
// back end's job register, and then in the output register before it is presented on the
// master side. Further results of the same character follow one a cycle while the master side accepts them.
// Throughput: one character per cycle while the job queue has room; the back end delivers
// one result per cycle while the master side accepts, and a group of four characters yields at most four results.
// Reset: aresetn is synchronous and active low; it empties the queue and clears all message state.

module base64_stream_decoder #(
    parameter int FIFO_DEPTH = b64d_pkg::DEFAULT_FIFO_DEPTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Character channel.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [b64d_pkg::S_TDATA_W-1:0]   s_tdata,   // [7:0] char_code
    input  logic                             s_tlast,   // end_of_message
    // Result channel.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [b64d_pkg::M_TDATA_W-1:0]   m_tdata,   // [7:0] out_byte, [9:8] decode_status,
                                                        // [15:10] zero
    output logic                             m_tuser,   // byte_valid
    output logic                             m_tlast    // last_result
);
    import b64d_pkg::*;

    // The front end classifies each character, keeps the partial group and the sticky
    // error flag, and turns a completed group or a message end into one job. The job
    // queue decouples it from the back end, which spreads a job over up to four
    // result transfers. A group whose bytes are all suppressed and that does not end
    // the message creates no job at all.
    job_t push_job;
    job_t head_job;
    logic push;
    logic pop;
    logic queue_full;
    logic queue_empty;

    b64d_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_char    (s_tdata),
        .in_last    (s_tlast),
        .queue_full (queue_full),
        .in_ready   (s_tready),
        .push       (push),
        .push_job   (push_job)
    );

    b64d_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .full     (queue_full),
        .empty    (queue_empty)
    );

    // The back end registers every result, so the master side never depends
    // combinationally on m_tready.
    b64d_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_job    (head_job),
        .queue_empty (queue_empty),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_data    (m_tdata),
        .out_user    (m_tuser),
        .out_last    (m_tlast)
    );

endmodule

### design/b64d_front.sv
`timescale 1ns / 1ps

module b64d_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic [7:0]        in_char,
    input  logic              in_last,
    input  logic              queue_full,
    output logic              in_ready,
    output logic              push,
    output b64d_pkg::job_t    push_job
);
    import b64d_pkg::*;

    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_SP  = 8'h20;
    localparam logic [7:0] CHAR_TAB = 8'h09;
    localparam logic [7:0] CHAR_PAD = 8'h3D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [5:0] SEXTET_PLUS  = 6'd62;
    localparam logic [5:0] SEXTET_SLASH = 6'd63;
    localparam logic [5:0] LOWER_BASE   = 6'd26;
    localparam logic [5:0] DIGIT_BASE   = 6'd52;

    // Bit 6 of a slot flags padding or any other character outside the alphabet, bits 5..0 hold the sextet.
    logic [6:0] slot_reg [0:2];
    logic [1:0] slot_count_reg;
    logic [1:0] slot_count_next;
    logic       error_reg;
    logic       error_next;

    logic       accept;
    logic       skip;
    logic       known;
    logic [5:0] sextet;
    logic [6:0] new_slot;
    logic       group_done;
    logic       d0, d1, d2, d3;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    always_comb begin
        skip = (in_char == CHAR_LF) || (in_char == CHAR_CR) ||
               (in_char == CHAR_SP) || (in_char == CHAR_TAB);
        known  = 1'b1;
        sextet = 6'd0;
        if (in_char >= 8'h41 && in_char <= 8'h5A) begin
            sextet = 6'(in_char - 8'h41);
        end else if (in_char >= 8'h61 && in_char <= 8'h7A) begin
            sextet = 6'(in_char - 8'h61) + LOWER_BASE;
        end else if (in_char >= 8'h30 && in_char <= 8'h39) begin
            sextet = 6'(in_char - 8'h30) + DIGIT_BASE;
        end else if (in_char == CHAR_PLUS) begin
            sextet = SEXTET_PLUS;
        end else if (in_char == CHAR_SLASH) begin
            sextet = SEXTET_SLASH;
        end else begin
            known = 1'b0;
        end

        if (known) begin
            new_slot = {1'b0, sextet};
        end else begin
            new_slot = 7'h40;
        end

        error_next      = error_reg || (!skip && !known && in_char != CHAR_PAD);
        group_done      = !skip && (slot_count_reg == 2'd3);
        slot_count_next = skip ? slot_count_reg : slot_count_reg + 2'd1;

        d0 = !slot_reg[0][6];
        d1 = !slot_reg[1][6];
        d2 = !slot_reg[2][6];
        d3 = !new_slot[6];

        push_job.bytes[0] = {slot_reg[0][5:0], slot_reg[1][5:4]};
        push_job.bytes[1] = {slot_reg[1][3:0], slot_reg[2][5:2]};
        push_job.bytes[2] = {slot_reg[2][1:0], new_slot[5:0]};
        push_job.byte_mask = {d2 && d3, d1 && d2, d0 && d1} &
                             {3{group_done && !error_next}};
        push_job.has_status = in_last;
        if (slot_count_next != 2'd0) begin
            push_job.status = STATUS_BAD_LENGTH;
        end else if (error_next) begin
            push_job.status = STATUS_BAD_CHAR;
        end else begin
            push_job.status = STATUS_OK;
        end

        push = accept && ((|push_job.byte_mask) || in_last);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_count_reg <= 2'd0;
            error_reg      <= 1'b0;
        end else if (accept) begin
            if (in_last) begin
                slot_count_reg <= 2'd0;
                error_reg      <= 1'b0;
            end else begin
                slot_count_reg <= slot_count_next;
                error_reg      <= error_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && !skip && slot_count_reg != 2'd3) begin
            slot_reg[slot_count_reg] <= new_slot;
        end
    end

endmodule

### design/b64d_fifo.sv
`timescale 1ns / 1ps

module b64d_fifo #(
    parameter int DEPTH = b64d_pkg::DEFAULT_FIFO_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  b64d_pkg::job_t    push_job,
    input  logic              pop,
    output b64d_pkg::job_t    head_job,
    output logic              full,
    output logic              empty
);
    import b64d_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             entry_mem [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = entry_mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### design/b64d_back.sv
`timescale 1ns / 1ps

module b64d_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  b64d_pkg::job_t                    head_job,
    input  logic                              queue_empty,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [b64d_pkg::M_TDATA_W-1:0]    out_data,
    output logic                              out_user,
    output logic                              out_last
);
    import b64d_pkg::*;

    logic                 job_valid_reg;
    logic                 job_valid_next;
    job_t                 job_reg;
    job_t                 job_next;
    job_t                 job_after;
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic [M_TDATA_W-1:0] item_data;
    logic                 out_user_reg;
    logic                 out_last_reg;
    logic                 item_is_byte;
    logic                 out_free;
    logic                 emit;
    logic                 job_done;

    assign out_free = !out_valid_reg || out_ready;
    assign emit     = job_valid_reg && out_free;

    always_comb begin
        job_after    = job_reg;
        item_is_byte = 1'b1;
        item_data    = '0;
        if (job_reg.byte_mask[0]) begin
            item_data[7:0]         = job_reg.bytes[0];
            job_after.byte_mask[0] = 1'b0;
        end else if (job_reg.byte_mask[1]) begin
            item_data[7:0]         = job_reg.bytes[1];
            job_after.byte_mask[1] = 1'b0;
        end else if (job_reg.byte_mask[2]) begin
            item_data[7:0]         = job_reg.bytes[2];
            job_after.byte_mask[2] = 1'b0;
        end else begin
            item_is_byte         = 1'b0;
            item_data[9:8]       = job_reg.status;
            job_after.has_status = 1'b0;
        end

        job_done = emit && (job_after.byte_mask == 3'b000) && !job_after.has_status;
        pop      = !queue_empty && (!job_valid_reg || job_done);

        if (pop) begin
            job_valid_next = 1'b1;
            job_next       = head_job;
        end else if (emit) begin
            job_valid_next = !job_done;
            job_next       = job_after;
        end else begin
            job_valid_next = job_valid_reg;
            job_next       = job_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            job_valid_reg <= job_valid_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        job_reg <= job_next;
        if (emit) begin
            out_data_reg <= item_data;
            out_user_reg <= item_is_byte;
            out_last_reg <= !item_is_byte;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_user  = out_user_reg;
    assign out_last  = out_last_reg;

endmodule

### design/b64d_checker.sv
`timescale 1ns / 1ps

module b64d_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [b64d_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic                             m_tuser,
    input logic                             m_tlast
);
    import b64d_pkg::*;

    // Nothing is offered in the cycle after reset.
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result offered straight after reset");

    // A stalled result holds its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result changed");

    // A data byte carries no status and never closes a message.
    a_byte_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[9:8] == STATUS_OK && !m_tlast)
        else $error("data byte with status or last");

    // A status result closes the message, has a zero byte and a defined code.
    a_status_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast && m_tdata[7:0] == 8'd0 && m_tdata[9:8] != 2'd3
                                 && m_tdata[15:10] == '0)
        else $error("malformed status result");

    // The queue is empty straight after reset, so the input side must be ready.
    a_ready_after_reset: assert property (@(posedge aclk) !aresetn |=> s_tready)
        else $error("input not ready after reset");

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
